### hdl/duration_string_parser_unit_assert.svh
// assertion macros for the duration string parser
// used by the top level; checks vanish when SYNTHESIS is defined
`ifndef DURATION_STRING_PARSER_UNIT_ASSERT_SVH
`define DURATION_STRING_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property that holds on every clock edge out of reset
`define DSP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: check failed");
// implication whose consequent is checked in the next cycle
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define DSP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/dsp_pkg.sv
// shared types, character codes and suffix trie for the duration string parser
// no dependencies; imported by every module of the block
package dsp_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int SEC_BITS = 17;
    localparam int SEC_PER_MIN_I  = 60;
    localparam int SEC_PER_HOUR_I = 60 * 60;
    localparam int SEC_PER_DAY_I  = 24 * 60 * 60;
    localparam int MAX_SECONDS_I  = 86400;

    localparam logic [SEC_BITS-1:0] MAX_SECONDS  = SEC_BITS'(MAX_SECONDS_I);
    localparam logic [SEC_BITS-1:0] SEC_PER_MIN  = SEC_BITS'(SEC_PER_MIN_I);
    localparam logic [SEC_BITS-1:0] SEC_PER_HOUR = SEC_BITS'(SEC_PER_HOUR_I);
    localparam logic [SEC_BITS-1:0] SEC_PER_DAY  = SEC_BITS'(SEC_PER_DAY_I);
    localparam logic [SEC_BITS-1:0] MAX_MINUTES  = SEC_BITS'(MAX_SECONDS_I / SEC_PER_MIN_I);
    localparam logic [SEC_BITS-1:0] MAX_HOURS    = SEC_BITS'(MAX_SECONDS_I / SEC_PER_HOUR_I);
    localparam logic [SEC_BITS-1:0] MAX_DAYS     = SEC_BITS'(MAX_SECONDS_I / SEC_PER_DAY_I);

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_SIGNED  = 3'd1,
        PH_DIGITS  = 3'd2,
        PH_SUFFIX  = 3'd3,
        PH_NODIGIT = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PARSE  = 2'd1,
        ST_SUFFIX = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        UNIT_NONE = 3'd0,
        UNIT_SEC  = 3'd1,
        UNIT_MIN  = 3'd2,
        UNIT_HOUR = 3'd3,
        UNIT_DAY  = 3'd4
    } t_unit;

    // one node per prefix of the accepted suffix words
    typedef enum logic [4:0] {
        ND_ROOT = 5'd0,
        ND_S, ND_SE, ND_SEC, ND_SECO, ND_SECON, ND_SECOND, ND_SECONDS,
        ND_M, ND_MI, ND_MIN, ND_MINU, ND_MINUT, ND_MINUTE, ND_MINUTES,
        ND_H, ND_HR, ND_HO, ND_HOU, ND_HOUR, ND_HOURS,
        ND_D, ND_DA, ND_DAY, ND_DAYS,
        ND_DEAD = 5'd31
    } t_node;

    typedef struct packed {
        logic       clear;
        logic       digit_en;
        logic [3:0] digit;
        logic       suffix_en;
        logic       suffix_root;
    } t_step;

    function automatic t_node next_node(input t_node node, input logic [7:0] c);
        t_node nx;
        nx = ND_DEAD;
        case (node)
            ND_ROOT: begin
                if (c == CH_SPACE || c == CH_TAB) nx = ND_ROOT;
                else if (c == "s") nx = ND_S;
                else if (c == "m") nx = ND_M;
                else if (c == "h") nx = ND_H;
                else if (c == "d") nx = ND_D;
            end
            ND_S:      if (c == "e") nx = ND_SE;
            ND_SE:     if (c == "c") nx = ND_SEC;
            ND_SEC:    if (c == "o") nx = ND_SECO;
            ND_SECO:   if (c == "n") nx = ND_SECON;
            ND_SECON:  if (c == "d") nx = ND_SECOND;
            ND_SECOND: if (c == "s") nx = ND_SECONDS;
            ND_M:      if (c == "i") nx = ND_MI;
            ND_MI:     if (c == "n") nx = ND_MIN;
            ND_MIN:    if (c == "u") nx = ND_MINU;
            ND_MINU:   if (c == "t") nx = ND_MINUT;
            ND_MINUT:  if (c == "e") nx = ND_MINUTE;
            ND_MINUTE: if (c == "s") nx = ND_MINUTES;
            ND_H: begin
                if (c == "r") nx = ND_HR;
                else if (c == "o") nx = ND_HO;
            end
            ND_HO:     if (c == "u") nx = ND_HOU;
            ND_HOU:    if (c == "r") nx = ND_HOUR;
            ND_HOUR:   if (c == "s") nx = ND_HOURS;
            ND_D:      if (c == "a") nx = ND_DA;
            ND_DA:     if (c == "y") nx = ND_DAY;
            ND_DAY:    if (c == "s") nx = ND_DAYS;
            default:   nx = ND_DEAD;
        endcase
        return nx;
    endfunction

    function automatic t_unit node_unit(input t_node node);
        t_unit u;
        case (node)
            ND_ROOT, ND_S, ND_SEC, ND_SECOND, ND_SECONDS: u = UNIT_SEC;
            ND_M, ND_MIN, ND_MINUTE, ND_MINUTES:          u = UNIT_MIN;
            ND_H, ND_HR, ND_HOUR, ND_HOURS:               u = UNIT_HOUR;
            ND_D, ND_DAY, ND_DAYS:                        u = UNIT_DAY;
            default:                                      u = UNIT_NONE;
        endcase
        return u;
    endfunction

    function automatic logic [SEC_BITS-1:0] unit_seconds(input t_unit u);
        logic [SEC_BITS-1:0] s;
        case (u)
            UNIT_MIN:  s = SEC_PER_MIN;
            UNIT_HOUR: s = SEC_PER_HOUR;
            UNIT_DAY:  s = SEC_PER_DAY;
            default:   s = SEC_BITS'(1);
        endcase
        return s;
    endfunction

    // largest count of the unit that still fits in one day
    function automatic logic [SEC_BITS-1:0] unit_max_count(input t_unit u);
        logic [SEC_BITS-1:0] m;
        case (u)
            UNIT_MIN:  m = MAX_MINUTES;
            UNIT_HOUR: m = MAX_HOURS;
            UNIT_DAY:  m = MAX_DAYS;
            default:   m = MAX_SECONDS;
        endcase
        return m;
    endfunction

endpackage

### hdl/dsp_digit_acc.sv
// decimal magnitude accumulator with sticky overflow flag
// depends on dsp_pkg (t_step)
module dsp_digit_acc
    import dsp_pkg::*;
#(
    parameter int ACC_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_step               i_step,
    output logic [ACC_BITS-1:0] o_magnitude,
    output logic                o_overflowed
);

    localparam int WIDE = ACC_BITS + 4;

    logic [ACC_BITS-1:0] r_magnitude, n_magnitude;
    logic                r_overflowed, n_overflowed;
    logic [WIDE-1:0]     mag_x, times_ten, limit;

    assign mag_x     = {4'b0, r_magnitude};
    assign times_ten = (mag_x << 3) + (mag_x << 1) + {{(WIDE-4){1'b0}}, i_step.digit};
    assign limit     = {{(WIDE-1){1'b0}}, 1'b1} << (ACC_BITS - 1);

    // 10*m + d above the limit is the overflow test, same as m > (lim - d) / 10
    always_comb begin
        n_magnitude  = r_magnitude;
        n_overflowed = r_overflowed;
        if (i_step.clear) begin
            n_magnitude  = '0;
            n_overflowed = 1'b0;
        end else if (i_step.digit_en && !r_overflowed) begin
            if (times_ten > limit) begin
                n_overflowed = 1'b1;
            end else begin
                n_magnitude = times_ten[ACC_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magnitude  <= '0;
            r_overflowed <= 1'b0;
        end else begin
            r_magnitude  <= n_magnitude;
            r_overflowed <= n_overflowed;
        end
    end

    assign o_magnitude  = r_magnitude;
    assign o_overflowed = r_overflowed;

endmodule

### hdl/dsp_suffix_match.sv
// unit suffix matcher: walks the suffix trie one character per beat
// depends on dsp_pkg (t_step, t_node, next_node, node_unit)
module dsp_suffix_match
    import dsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_step      i_step,
    input  logic [7:0] i_ch,
    output t_unit      o_unit
);

    t_node r_node, n_node;

    always_comb begin
        n_node = r_node;
        if (i_step.clear) begin
            n_node = ND_ROOT;
        end else if (i_step.suffix_en) begin
            n_node = next_node(i_step.suffix_root ? ND_ROOT : r_node, i_ch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= ND_ROOT;
        end else begin
            r_node <= n_node;
        end
    end

    assign o_unit = node_unit(r_node);

endmodule

### hdl/dsp_result_calc.sv
// final status and seconds from the accumulated number and matched unit
// depends on dsp_pkg (t_status, t_unit, unit tables)
module dsp_result_calc
    import dsp_pkg::*;
#(
    parameter int ACC_BITS = 64
) (
    input  logic                i_in_number,
    input  logic                i_negative,
    input  logic [ACC_BITS-1:0] i_magnitude,
    input  logic                i_overflowed,
    input  t_unit               i_unit,
    output t_status             o_status,
    output logic [SEC_BITS-1:0] o_seconds
);

    logic                  ovf;
    logic                  too_big;
    logic [2*SEC_BITS-1:0] product;

    // magnitude never exceeds 2^(ACC_BITS-1), so the top bit marks equality
    assign ovf     = i_overflowed || (!i_negative && i_magnitude[ACC_BITS-1]);
    assign too_big = (|i_magnitude[ACC_BITS-1:SEC_BITS])
                     || (i_magnitude[SEC_BITS-1:0] > unit_max_count(i_unit));
    assign product = i_magnitude[SEC_BITS-1:0] * unit_seconds(i_unit);

    always_comb begin
        o_status  = ST_PARSE;
        o_seconds = '0;
        if (i_in_number) begin
            if (ovf) begin
                o_status = ST_PARSE;
            end else if (i_unit == UNIT_NONE) begin
                o_status = ST_SUFFIX;
            end else if (i_negative && (|i_magnitude)) begin
                o_status = ST_RANGE;
            end else if (too_big) begin
                o_status = ST_RANGE;
            end else begin
                o_status  = ST_OK;
                o_seconds = product[SEC_BITS-1:0];
            end
        end
    end

endmodule

### hdl/duration_string_parser_unit.sv
// duration string parser: one character per beat, NUL ends the string
// a NUL beat is captured in the input register, then its result is registered onto o_status/o_seconds
// throughput: one character per cycle; the input register holds back only a NUL
// whose result slot is still occupied by a stalled result
// reset: synchronous active-low i_rst_n clears the parse state and both valid flags
module duration_string_parser_unit
    import dsp_pkg::*;
#(
    parameter int ACC_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_ch,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [SEC_BITS-1:0] o_seconds
);

`include "duration_string_parser_unit_assert.svh"

    logic                r_in_valid;
    logic [7:0]          r_ch;
    t_phase              r_phase, n_phase;
    logic                r_negative, n_negative;
    logic                r_out_valid, n_out_valid;
    t_status             r_status;
    logic [SEC_BITS-1:0] r_seconds;

    t_step               step;
    logic                is_nul, is_digit, is_ws, is_sign;
    logic                fire, load_result;
    logic [ACC_BITS-1:0] magnitude;
    logic                overflowed;
    t_unit               unit;
    t_status             calc_status;
    logic [SEC_BITS-1:0] calc_seconds;

    assign is_nul   = (r_ch == CH_NUL);
    assign is_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign is_ws    = (r_ch == CH_SPACE) || ((r_ch >= CH_TAB) && (r_ch <= CH_CR));
    assign is_sign  = (r_ch == CH_PLUS) || (r_ch == CH_MINUS);

    // only a terminator needs the result slot
    assign fire       = r_in_valid && (!is_nul || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    always_comb begin
        n_phase          = r_phase;
        n_negative       = r_negative;
        load_result      = 1'b0;
        step.clear       = 1'b0;
        step.digit_en    = 1'b0;
        step.digit       = r_ch[3:0];
        step.suffix_en   = 1'b0;
        step.suffix_root = 1'b0;
        if (fire) begin
            if (is_nul) begin
                load_result = 1'b1;
                step.clear  = 1'b1;
                n_phase     = PH_LEAD;
                n_negative  = 1'b0;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (is_ws) begin
                            n_phase = PH_LEAD;
                        end else if (is_sign) begin
                            n_negative = (r_ch == CH_MINUS);
                            n_phase    = PH_SIGNED;
                        end else if (is_digit) begin
                            step.digit_en = 1'b1;
                            n_phase       = PH_DIGITS;
                        end else begin
                            n_phase = PH_NODIGIT;
                        end
                    end
                    PH_SIGNED: begin
                        if (is_digit) begin
                            step.digit_en = 1'b1;
                            n_phase       = PH_DIGITS;
                        end else begin
                            n_phase = PH_NODIGIT;
                        end
                    end
                    PH_DIGITS: begin
                        if (is_digit) begin
                            step.digit_en = 1'b1;
                        end else begin
                            step.suffix_en   = 1'b1;
                            step.suffix_root = 1'b1;
                            n_phase          = PH_SUFFIX;
                        end
                    end
                    PH_SUFFIX: begin
                        step.suffix_en = 1'b1;
                    end
                    default: begin
                        n_phase = PH_NODIGIT;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_result) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    dsp_digit_acc #(
        .ACC_BITS(ACC_BITS)
    ) u_digit_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .o_magnitude (magnitude),
        .o_overflowed(overflowed)
    );

    dsp_suffix_match u_suffix_match (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_ch   (r_ch),
        .o_unit (unit)
    );

    dsp_result_calc #(
        .ACC_BITS(ACC_BITS)
    ) u_result_calc (
        .i_in_number (r_phase == PH_DIGITS || r_phase == PH_SUFFIX),
        .i_negative  (r_negative),
        .i_magnitude (magnitude),
        .i_overflowed(overflowed),
        .i_unit      (unit),
        .o_status    (calc_status),
        .o_seconds   (calc_seconds)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_LEAD;
            r_negative  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_phase     <= n_phase;
            r_negative  <= n_negative;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_ch <= i_ch;
        end
        if (load_result) begin
            r_status  <= calc_status;
            r_seconds <= calc_seconds;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_seconds   = r_seconds;

    `DSP_ASSERT_ALWAYS(a_err_zero_secs, i_clk, i_rst_n,
        !r_out_valid || r_status == ST_OK || r_seconds == '0)
    `DSP_ASSERT_ALWAYS(a_secs_in_day, i_clk, i_rst_n,
        !r_out_valid || r_seconds <= MAX_SECONDS)
    `DSP_ASSERT_ALWAYS(a_stall_only_on_full, i_clk, i_rst_n,
        !o_in_stall || (r_out_valid && i_out_stall && is_nul))
    `DSP_ASSERT_NEXT(a_nul_restarts, i_clk, i_rst_n,
        load_result, r_out_valid && r_phase == PH_LEAD && !r_negative)

endmodule

### bench/duration_string_parser_unit_check.sv
// result checker for the duration string parser: follows both beat channels,
// predicts each string's status and seconds and compares them in order
// depends on dsp_pkg for the phase and status codes and the character constants
module duration_string_parser_unit_check
    import dsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [7:0]          i_ch,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [1:0]          i_status,
    input  logic [SEC_BITS-1:0] i_seconds,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // one past the largest signed 64-bit value
    localparam logic [67:0] MAG_LIMIT = 68'h8000_0000_0000_0000;

    typedef struct {
        t_status             status;
        logic [SEC_BITS-1:0] seconds;
    } t_duration;

    t_duration   due_results[$];
    t_duration   oldest;
    int          fails;
    int          checked;

    t_phase      phase;
    logic        negative;
    logic [63:0] magnitude;
    logic        too_big;
    logic [63:0] unit_word;
    int unsigned word_len;

    task automatic clear_parse();
        phase     = PH_LEAD;
        negative  = 1'b0;
        magnitude = '0;
        too_big   = 1'b0;
        unit_word = '0;
        word_len  = 0;
    endtask

    task automatic take_digit(input logic [7:0] c);
        logic [67:0] grown;
        grown = {4'd0, magnitude} * 68'd10 + 68'(c - CH_ZERO);
        if (!too_big) begin
            if (grown > MAG_LIMIT) too_big = 1'b1;
            else magnitude = grown[63:0];
        end
    endtask

    // blanks are skipped only until the unit word starts
    task automatic take_unit_char(input logic [7:0] c);
        if (!(word_len == 0 && (c == CH_SPACE || c == CH_TAB))) begin
            unit_word = {unit_word[55:0], c};
            word_len++;
        end
    endtask

    function automatic int unsigned word_scale(input logic [63:0] w, input int unsigned n);
        if (n == 0) return 1;
        if (n > 7) return 0;
        case (w)
            "s", "sec", "second", "seconds": return 1;
            "m", "min", "minute", "minutes": return 60;
            "h", "hr", "hour", "hours":      return 60 * 60;
            "d", "day", "days":              return 24 * 60 * 60;
            default:                         return 0;
        endcase
    endfunction

    task automatic parse_char(input logic [7:0] c);
        logic digit;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        case (phase)
            PH_LEAD: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    // leading blanks dropped
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    negative = (c == CH_MINUS);
                    phase = PH_SIGNED;
                end else if (digit) begin
                    take_digit(c);
                    phase = PH_DIGITS;
                end else begin
                    phase = PH_NODIGIT;
                end
            end
            PH_SIGNED: begin
                if (digit) begin
                    take_digit(c);
                    phase = PH_DIGITS;
                end else begin
                    phase = PH_NODIGIT;
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    take_digit(c);
                end else begin
                    phase = PH_SUFFIX;
                    take_unit_char(c);
                end
            end
            PH_SUFFIX: take_unit_char(c);
            default:   phase = PH_NODIGIT;
        endcase
    endtask

    function automatic t_duration close_string();
        t_duration   r;
        int unsigned scale;
        r.status  = ST_PARSE;
        r.seconds = '0;
        if (phase == PH_DIGITS || phase == PH_SUFFIX) begin
            scale = word_scale(unit_word, word_len);
            // overflow wins over a bad unit word
            if (too_big || (!negative && magnitude == MAG_LIMIT[63:0])) begin
                r.status = ST_PARSE;
            end else if (scale == 0) begin
                r.status = ST_SUFFIX;
            end else if (negative && magnitude != 0) begin
                r.status = ST_RANGE;
            end else if (magnitude > 64'(MAX_SECONDS_I / scale)) begin
                r.status = ST_RANGE;
            end else begin
                r.status  = ST_OK;
                r.seconds = SEC_BITS'(magnitude * scale);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with nothing expected (status %0d seconds %0d)",
                             $time, i_status, i_seconds);
                end else begin
                    oldest = due_results.pop_front();
                    checked++;
                    if (i_status !== oldest.status) begin
                        fails++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest.status, i_status);
                    end
                    if (i_seconds !== oldest.seconds) begin
                        fails++;
                        $display("%0t: seconds expected %0d, got %0d",
                                 $time, oldest.seconds, i_seconds);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_ch == CH_NUL) begin
                    due_results.push_back(close_string());
                    clear_parse();
                end else begin
                    parse_char(i_ch);
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

### bench/duration_string_parser_unit_test.sv
// top of the duration string parser bench: clock, reset, string stimulus and verdict
// depends on dsp_pkg, the parser block and duration_string_parser_unit_check
module duration_string_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dsp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 380;

    // pacing styles for either side
    localparam int PACE_EAGER  = 0;
    localparam int PACE_RANDOM = 1;
    localparam int PACE_BURSTY = 2;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          ch;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic [SEC_BITS-1:0] seconds;

    int         fail_count;
    int         pending;
    int         checked;
    int         tx_mode = PACE_RANDOM;
    int         rx_mode = PACE_RANDOM;
    logic       hold_go = 1'b0;
    logic       hold_served = 1'b0;
    int         chars_sent = 0;
    int         strings_sent = 0;
    logic [7:0] text_q[$];

    always #5ns clk = ~clk;

    duration_string_parser_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_ch        (ch),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_seconds   (seconds)
    );

    duration_string_parser_unit_check result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_ch         (ch),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_seconds    (seconds),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic int pick_gap(input int mode);
        case (mode)
            PACE_EAGER:  return 0;
            PACE_RANDOM: return $urandom_range(0, 18);
            default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    task automatic add_byte(input logic [7:0] c);
        text_q.push_back(c);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = pick_gap(tx_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i]);
        send_char(CH_NUL);
        text_q.delete();
        strings_sent++;
    endtask

    task automatic run_text(input string s);
        add_text(s);
        send_text();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic make_random_text();
        int          r;
        int          pos;
        int unsigned cap;
        int unsigned v;
        t_unit       u;
        string       w;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            // raw noise, any non-NUL byte
            repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 1)) add_byte(CH_SPACE);
                else add_byte(8'($urandom_range(CH_TAB, CH_CR)));
            end
            r = $urandom_range(0, 9);
            if (r < 2) add_byte(CH_MINUS);
            else if (r == 2) add_byte(CH_PLUS);
            u = t_unit'($urandom_range(UNIT_NONE, UNIT_DAY));
            case (u)
                UNIT_MIN:  cap = 1440;
                UNIT_HOUR: cap = 24;
                UNIT_DAY:  cap = 1;
                default:   cap = 86400;
            endcase
            case ($urandom_range(0, 5))
                0:       v = cap;
                1:       v = cap + 1;
                2:       v = 0;
                default: v = $urandom_range(0, cap + cap / 4 + 1);
            endcase
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // long digit runs straddle the 64-bit limit
                add_byte(8'(CH_ZERO + $urandom_range(1, 9)));
                repeat ($urandom_range(16, 20)) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            end else begin
                if (r == 1) repeat ($urandom_range(1, 4)) add_byte(CH_ZERO);
                add_text($sformatf("%0d", v));
            end
            repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            case (u)
                UNIT_SEC: begin
                    case ($urandom_range(0, 3))
                        0:       w = "s";
                        1:       w = "sec";
                        2:       w = "second";
                        default: w = "seconds";
                    endcase
                end
                UNIT_MIN: begin
                    case ($urandom_range(0, 3))
                        0:       w = "m";
                        1:       w = "min";
                        2:       w = "minute";
                        default: w = "minutes";
                    endcase
                end
                UNIT_HOUR: begin
                    case ($urandom_range(0, 3))
                        0:       w = "h";
                        1:       w = "hr";
                        2:       w = "hour";
                        default: w = "hours";
                    endcase
                end
                UNIT_DAY: begin
                    case ($urandom_range(0, 2))
                        0:       w = "d";
                        1:       w = "day";
                        default: w = "days";
                    endcase
                end
                default: w = "";
            endcase
            add_text(w);
            // now and then spoil the unit word
            if (w.len() > 0 && $urandom_range(0, 5) == 0) begin
                pos = text_q.size() - 1 - $urandom_range(0, w.len() - 1);
                case ($urandom_range(0, 3))
                    0:       add_byte(CH_SPACE);
                    1:       add_byte("x");
                    2:       text_q[pos] = 8'($urandom_range(1, 255));
                    default: text_q[pos] = text_q[pos] - 8'h20;
                endcase
            end
        end
    endtask

    // output side: per-result stall, plus one long hold-off on request
    initial begin : receiver
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go && !hold_served) begin
                n = HOLD_CYCLES;
                hold_served = 1'b1;
            end else begin
                if ($urandom_range(0, 15) == 0) rx_mode = $urandom_range(PACE_EAGER, PACE_BURSTY);
                n = pick_gap(rx_mode);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
            else idle++;
        end
        $display("%0t: no beat on either channel for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int  base;
        logic burst_done;
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = CH_NUL;
        burst_done = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty string, a blank-only string and leading blanks before a number
        send_text();
        run_text("   ");
        add_byte(CH_SPACE);
        for (int c = CH_TAB; c <= CH_CR; c++) add_byte(8'(c));
        add_text("42s");
        send_text();
        // sign and junk with no digits
        run_text("+");
        run_text("- 5");
        run_text("abc");
        add_byte(8'hFF);
        send_text();
        // zero, signs and the one-day bound in every unit
        run_text("-0d");
        run_text("-5");
        run_text("+86400");
        run_text("86401");
        run_text("00000000000000000000086400s");
        run_text("1440m");
        run_text("1441min");
        run_text("24 hours");
        run_text("25h");
        add_text("1 ");
        add_byte(CH_TAB);
        add_text("day");
        send_text();
        run_text("2days");
        run_text("9second");
        run_text("3minutes");
        run_text("4hr");
        run_text("7sec");
        // bad unit words
        run_text("5s ");
        run_text("5S");
        run_text("5 secondss");
        add_text("5");
        add_byte(8'h80);
        send_text();
        // 64-bit magnitude limit
        run_text("9223372036854775807");
        run_text("9223372036854775808");
        run_text("-9223372036854775808");
        run_text("-9223372036854775809");
        run_text("123456789012345678901xyz");
        drain();

        base = chars_sent;
        while (chars_sent - base < RANDOM_CHARS) begin
            if (!burst_done && chars_sent - base >= RANDOM_CHARS / 2) begin
                // back-to-back short strings against a held output
                hold_go = 1'b1;
                tx_mode = PACE_EAGER;
                repeat (24) begin
                    add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                    send_text();
                end
                drain();
                burst_done = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) tx_mode = $urandom_range(PACE_EAGER, PACE_BURSTY);
            make_random_text();
            send_text();
            if ($urandom_range(0, 19) == 0) drain();
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (8) @(posedge clk);
        $display("covered %0d characters in %0d strings, %0d results compared",
                 chars_sent, strings_sent, checked);
        $display("with a %0d-cycle output hold-off and several full drains",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/dsp_pkg.sv
hdl/dsp_digit_acc.sv
hdl/dsp_suffix_match.sv
hdl/dsp_result_calc.sv
hdl/duration_string_parser_unit.sv
bench/duration_string_parser_unit_check.sv
bench/duration_string_parser_unit_test.sv
